// ===== rtl/three_axis_step_slot_scheduler_defines.svh =====
// Assertion macros for the step slot scheduler.
`ifndef THREE_AXIS_STEP_SLOT_SCHEDULER_DEFINES_SVH
`define THREE_AXIS_STEP_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TASS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define TASS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== rtl/tass_pkg.sv =====
// Package: constants, types and the step gap table of the step slot scheduler.
`default_nettype none
package tass_pkg;

  localparam int SLOTS   = 256;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int SPEED_W = 10;
  localparam int POS_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_Z = 2'd2;

  typedef logic [COUNT_W-1:0] gap_tab_t [SLOTS];

  // count how many times n fits into SLOTS by repeated subtraction
  function automatic gap_tab_t gap_table();
    gap_tab_t t;
    int       rem;
    int       q;
    for (int i = 0; i < SLOTS; i++) begin
      rem = SLOTS;
      q   = 0;
      while (rem > i) begin
        rem = rem - (i + 1);
        q   = q + 1;
      end
      t[i] = COUNT_W'(q);
    end
    return t;
  endfunction

  // Spacing between steps for n steps per pass, indexed by n-1.
  localparam gap_tab_t STEP_GAP = gap_table();

  typedef struct packed {
    logic              tick;
    logic              restart;
    logic [SLOT_W-1:0] slot;
  } axis_ctl_t;

  typedef struct packed {
    logic                    step_x;
    logic                    step_y;
    logic                    step_z;
    logic                    dir_pin_x;
    logic                    dir_pin_y;
    logic                    dir_pin_z;
    logic [SLOT_W-1:0]       slot_index;
    logic                    pass_end;
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] position_z;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tass_if.sv =====
// Interfaces: slot tick input channel and step result output channel.
`default_nettype none
interface tass_in_if;
  logic valid;
  logic ready;
  logic slot_tick;

  modport source (output valid, output slot_tick, input ready);
  modport sink   (input valid, input slot_tick, output ready);
endinterface

interface tass_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  step_x;
  logic                                  step_y;
  logic                                  step_z;
  logic                                  dir_pin_x;
  logic                                  dir_pin_y;
  logic                                  dir_pin_z;
  logic [tass_pkg::SLOT_W-1:0]           slot_index;
  logic                                  pass_end;
  logic signed [tass_pkg::POS_W-1:0]     position_x;
  logic signed [tass_pkg::POS_W-1:0]     position_y;
  logic signed [tass_pkg::POS_W-1:0]     position_z;

  modport source (output valid, output step_x, output step_y, output step_z,
                  output dir_pin_x, output dir_pin_y, output dir_pin_z,
                  output slot_index, output pass_end,
                  output position_x, output position_y, output position_z,
                  input ready);
  modport sink   (input valid, input step_x, input step_y, input step_z,
                  input dir_pin_x, input dir_pin_y, input dir_pin_z,
                  input slot_index, input pass_end,
                  input position_x, input position_y, input position_z,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/tass_axis.sv =====
// One axis: speed setup, step placement within the pass and position count.
`default_nettype none
module tass_axis (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [tass_pkg::SPEED_W-1:0]         cfg_data,
  input  wire tass_pkg::axis_ctl_t                  ctl,
  output logic                                      step,
  output logic                                      fwd,
  output logic signed [tass_pkg::POS_W-1:0]         pos_next
);

  logic [tass_pkg::COUNT_W-1:0]      steps;
  logic [tass_pkg::COUNT_W-1:0]      gap;
  logic [tass_pkg::COUNT_W-1:0]      next_slot;
  logic [tass_pkg::COUNT_W-1:0]      issued;
  logic signed [tass_pkg::POS_W-1:0] pos;

  logic [tass_pkg::SPEED_W-1:0]      mag;
  logic [tass_pkg::COUNT_W-1:0]      steps_next;
  logic [tass_pkg::SLOT_W-1:0]       gap_idx;

  always_comb begin
    mag = cfg_data[tass_pkg::SPEED_W-1] ? (~cfg_data + 1'b1) : cfg_data;
    if (mag > tass_pkg::SPEED_W'(tass_pkg::SLOTS)) begin
      steps_next = tass_pkg::COUNT_W'(tass_pkg::SLOTS);
    end else begin
      steps_next = mag[tass_pkg::COUNT_W-1:0];
    end
    gap_idx = tass_pkg::SLOT_W'(steps_next - 1'b1);
  end

  assign step = ctl.tick && (steps != '0) && (issued < steps)
                && ({1'b0, ctl.slot} == next_slot);

  always_comb begin
    if (!step) begin
      pos_next = pos;
    end else if (fwd) begin
      pos_next = pos + 1'b1;
    end else begin
      pos_next = pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps     <= '0;
      gap       <= '0;
      fwd       <= 1'b0;
      next_slot <= '0;
      issued    <= '0;
      pos       <= '0;
    end else begin
      if (cfg_we) begin
        steps <= steps_next;
        gap   <= tass_pkg::STEP_GAP[gap_idx];
        fwd   <= !cfg_data[tass_pkg::SPEED_W-1] && (cfg_data != '0);
      end
      pos <= pos_next;
      if (ctl.restart) begin
        next_slot <= '0;
        issued    <= '0;
      end else if (step) begin
        next_slot <= next_slot + gap;
        issued    <= issued + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/three_axis_step_slot_scheduler.sv =====
// Top level: three-axis step slot scheduler with output register and skid stage.
//
//  channel   dir  handshake        payload
//  in        in   valid/ready      slot_tick
//  out       out  valid/ready      step_*, dir_pin_*, slot_index, pass_end, position_*
//  cfg       in   cfg_we           cfg_index, cfg_data (speed_x, speed_y, speed_z)
//
// One item per cycle while in.ready is high; each result is registered in the output
// register, or in the skid stage first when the output is stalled.
// Reset clears speeds, positions and the pass; a speed write restarts the pass.
// A stalled result holds in the output register; one more item fits in the skid
// stage, then in.ready drops until the output drains.
`default_nettype none
`include "three_axis_step_slot_scheduler_defines.svh"
module three_axis_step_slot_scheduler (
  input  wire logic                               clk,
  input  wire logic                               rst,
  tass_in_if.sink                                 in,
  tass_out_if.source                              out,
  input  wire logic                               cfg_we,
  input  wire logic [tass_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tass_pkg::SPEED_W-1:0]       cfg_data
);

  logic [tass_pkg::SLOT_W-1:0] slot_counter;
  logic                        out_valid;
  logic                        skid_valid;
  tass_pkg::result_t           out_res;
  tass_pkg::result_t           skid_res;
  tass_pkg::result_t           res;

  logic              accept;
  logic              out_fire;
  logic              tick;
  logic              last;
  logic              cfg_hit;
  logic [2:0]        axis_we;
  logic [2:0]        step;
  logic [2:0]        fwd;
  logic signed [tass_pkg::POS_W-1:0] pos_next [3];
  tass_pkg::axis_ctl_t ctl;

  assign in.ready = !skid_valid;
  assign accept   = in.valid && in.ready;
  assign out_fire = out_valid && out.ready;
  assign tick     = accept && in.slot_tick;
  assign last     = tick && (slot_counter == tass_pkg::SLOT_W'(tass_pkg::SLOTS - 1));

  assign axis_we[0] = cfg_we && (cfg_index == tass_pkg::REG_SPEED_X);
  assign axis_we[1] = cfg_we && (cfg_index == tass_pkg::REG_SPEED_Y);
  assign axis_we[2] = cfg_we && (cfg_index == tass_pkg::REG_SPEED_Z);
  assign cfg_hit    = |axis_we;

  assign ctl.tick    = tick;
  assign ctl.restart = cfg_hit || last;
  assign ctl.slot    = slot_counter;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tass_axis u_axis (
      .clk      (clk),
      .rst      (rst),
      .cfg_we   (axis_we[a]),
      .cfg_data (cfg_data),
      .ctl      (ctl),
      .step     (step[a]),
      .fwd      (fwd[a]),
      .pos_next (pos_next[a])
    );
  end

  always_comb begin
    res.step_x     = step[0];
    res.step_y     = step[1];
    res.step_z     = step[2];
    res.dir_pin_x  = fwd[0];
    res.dir_pin_y  = !fwd[1];
    res.dir_pin_z  = !fwd[2];
    res.slot_index = slot_counter;
    res.pass_end   = last;
    res.position_x = pos_next[0];
    res.position_y = pos_next[1];
    res.position_z = pos_next[2];
  end

  // advance the slot counter, restart on pass end or speed write
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter <= '0;
    end else if (cfg_hit || last) begin
      slot_counter <= '0;
    end else if (tick) begin
      slot_counter <= slot_counter + 1'b1;
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (accept) begin
      if (out_valid && !out.ready) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign out.valid      = out_valid;
  assign out.step_x     = out_res.step_x;
  assign out.step_y     = out_res.step_y;
  assign out.step_z     = out_res.step_z;
  assign out.dir_pin_x  = out_res.dir_pin_x;
  assign out.dir_pin_y  = out_res.dir_pin_y;
  assign out.dir_pin_z  = out_res.dir_pin_z;
  assign out.slot_index = out_res.slot_index;
  assign out.pass_end   = out_res.pass_end;
  assign out.position_x = out_res.position_x;
  assign out.position_y = out_res.position_y;
  assign out.position_z = out_res.position_z;

  `TASS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `TASS_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid && !out.ready, skid_valid)
  `TASS_ASSERT_NOW(a_pass_end_slot, out_valid && out_res.pass_end,
                   out_res.slot_index == tass_pkg::SLOT_W'(tass_pkg::SLOTS - 1))
  `TASS_ASSERT_NEXT(a_report_holds_slot, accept && !in.slot_tick && !cfg_hit,
                    $stable(slot_counter))

endmodule
`default_nettype wire
